@@ rtl/aes_ke_pkg.sv @@
// Package for the AES-128 key expansion block: payload structs, S-box and round constants.
// No dependencies.
`default_nettype none
package aes_ke_pkg;

  localparam int ROUND_COUNT = 10;

  typedef struct packed {
    logic [63:0] key_hi;
    logic [63:0] key_lo;
  } key_in_t;

  typedef struct packed {
    logic [63:0] round_key_hi;
    logic [63:0] round_key_lo;
    logic [3:0]  round_index;
    logic        last;
  } key_out_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] rcon(input logic [3:0] round);
    logic [7:0] r;
    case (round)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sub_rot(input logic [31:0] w);
    logic [31:0] rot;
    rot = {w[23:0], w[31:24]};
    return {SBOX[rot[31:24]], SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]};
  endfunction

endpackage
`default_nettype wire

@@ rtl/aes_ke_round.sv @@
// One registered round of the AES-128 key schedule with a valid bit and stall hold.
// Depends on aes_ke_pkg.
`default_nettype none
module aes_ke_round #(
  parameter logic [3:0] ROUND = 4'd1
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         hold,
  input  wire logic         in_valid,
  input  wire logic [127:0] in_key,
  output logic              out_valid,
  output logic [127:0]      out_key
);
  logic [31:0] w0, w1, w2, w3;

  always_comb begin
    w0 = in_key[127:96] ^ aes_ke_pkg::sub_rot(in_key[31:0]) ^
         {aes_ke_pkg::rcon(ROUND), 24'd0};
    w1 = in_key[95:64] ^ w0;
    w2 = in_key[63:32] ^ w1;
    w3 = in_key[31:0] ^ w2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!hold) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      out_key <= {w0, w1, w2, w3};
    end
  end
endmodule
`default_nettype wire

@@ rtl/aes_ke_emit.sv @@
// Holds the eleven round keys of one cipher key and sends them one per cycle while stall is low.
// Depends on aes_ke_pkg.
`default_nettype none
module aes_ke_emit #(
  parameter int ROUND_COUNT = aes_ke_pkg::ROUND_COUNT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         key_order,
  input  wire logic         load,
  input  wire logic [127:0] keys_in [ROUND_COUNT+1],
  output logic              busy,
  output logic              valid,
  input  wire logic         stall,
  output aes_ke_pkg::key_out_t data
);
  logic [127:0] keys [ROUND_COUNT+1];
  logic [3:0]   count;
  logic         order;
  logic [3:0]   rnd;
  logic         done;

  assign done  = valid && !stall && (count == 4'(ROUND_COUNT));
  assign busy  = valid && !done;
  assign rnd   = order ? 4'(ROUND_COUNT) - count : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      count <= '0;
    end else if (load) begin
      valid <= 1'b1;
      count <= '0;
    end else if (done) begin
      valid <= 1'b0;
    end else if (valid && !stall) begin
      count <= count + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      keys  <= keys_in;
      order <= key_order;
    end
  end

  always_comb begin
    data.round_key_hi = keys[rnd][127:64];
    data.round_key_lo = keys[rnd][63:0];
    data.round_index  = rnd;
    data.last         = (count == 4'(ROUND_COUNT));
  end
endmodule
`default_nettype wire

@@ rtl/aes128_key_expansion_top.sv @@
// Top level of the AES-128 key expansion: ten pipelined rounds and an output sequencer.
// Depends on aes_ke_pkg, aes_ke_round and aes_ke_emit.
`default_nettype none
// A cipher key runs through a ten-stage pipeline, one round of the schedule per stage,
// and the finished set of eleven round keys is sent one per cycle while out_stall is low,
// forward or reversed by key_order as sampled when the set reaches the output. The output
// sequencer sets the pace: it takes a new set only once it has finished the last one,
// with later keys waiting in the pipeline meanwhile.
module aes128_key_expansion_top #(
  parameter int ROUND_COUNT = aes_ke_pkg::ROUND_COUNT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic                 cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire aes_ke_pkg::key_in_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output aes_ke_pkg::key_out_t      out_data
);
  logic                 key_order;
  logic                 v   [ROUND_COUNT+1];
  logic [127:0]         k   [ROUND_COUNT+1];
  logic [127:0]         snap [ROUND_COUNT+1];
  logic                 hold;
  logic                 busy;
  logic                 load;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_order <= 1'b0;
    end else if (cfg_write) begin
      key_order <= cfg_data;
    end
  end

  // The pipeline advances unless its finished key cannot move to the sequencer.
  assign hold     = v[ROUND_COUNT] && busy;
  assign load     = v[ROUND_COUNT] && !busy;
  assign in_stall = hold;
  assign v[0]     = in_valid;
  assign k[0]     = {in_data.key_hi, in_data.key_lo};

  genvar i;
  generate
    for (i = 1; i <= ROUND_COUNT; i++) begin : g_round
      aes_ke_round #(.ROUND(4'(i))) u_round (
        .clk(clk), .rst(rst), .hold(hold),
        .in_valid(v[i-1]), .in_key(k[i-1]),
        .out_valid(v[i]), .out_key(k[i])
      );
    end
  endgenerate

  // Stage i no longer holds round key i of a key by the time that key reaches stage 10, so keep
  // every round key alongside the data instead: carry them with a shift of snapshots.
  logic [127:0] hist [ROUND_COUNT+1][ROUND_COUNT+1];
  always_comb begin
    for (int r = 0; r <= ROUND_COUNT; r++) begin
      hist[0][r] = (r == 0) ? k[0] : 128'd0;
    end
  end
  generate
    for (i = 1; i <= ROUND_COUNT; i++) begin : g_hist
      for (genvar r = 0; r <= ROUND_COUNT; r++) begin : g_r
        if (r < i) begin : g_keep
          always_ff @(posedge clk) begin
            if (!hold) begin
              hist[i][r] <= hist[i-1][r];
            end
          end
        end else if (r == i) begin : g_new
          assign hist[i][r] = k[i];
        end else begin : g_zero
          assign hist[i][r] = 128'd0;
        end
      end
    end
  endgenerate

  always_comb begin
    for (int r = 0; r <= ROUND_COUNT; r++) begin
      snap[r] = hist[ROUND_COUNT][r];
    end
  end

  aes_ke_emit #(.ROUND_COUNT(ROUND_COUNT)) u_emit (
    .clk(clk), .rst(rst), .key_order(key_order), .load(load),
    .keys_in(snap), .busy(busy), .valid(out_valid), .stall(out_stall),
    .data(out_data)
  );

  a_last_round: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last |-> (out_data.round_index == 4'd0 ||
                                   out_data.round_index == 4'(ROUND_COUNT)))
    else $error("last mark on an inner round");
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v[ROUND_COUNT] && out_valid)
    else $error("pipeline held without a busy sequencer");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    $past(out_valid && out_stall) && !$past(rst) |-> out_valid)
    else $error("result dropped under stall");
endmodule
`default_nettype wire
